// ===== rtl/fct_pkg.sv =====
// ----------------------------------------------------------------------------
// fct_pkg
// Shared types and constants of the FAT16 cluster table engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fct_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int SIZE_W      = ADDR_W + 1;
    localparam int CLUS_W      = 16;
    localparam int CFG_W       = 13;
    localparam int FREED_W     = 13;
    localparam int STATUS_W    = 2;
    localparam int CMD_W       = 3;

    localparam int SIZE_MIN    = 3;

    localparam logic [CLUS_W-1:0] CLUS_FIRST = 16'h0002;
    localparam logic [CLUS_W-1:0] CLUS_LAST  = 16'hFFEF;
    localparam logic [CLUS_W-1:0] EOC_FIRST  = 16'hFFF8;
    localparam logic [CLUS_W-1:0] EOC_MARK   = 16'hFFFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_NEXT       = 3'd0,
        CMD_ALLOC      = 3'd1,
        CMD_FREE       = 3'd2,
        CMD_CHAIN      = 3'd3,
        CMD_MARK_LAST  = 3'd4,
        CMD_FREE_CHAIN = 3'd5,
        CMD_RAW_LOAD   = 3'd6
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_INVALID = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_BROKEN  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_ALLOC
    } t_state;

    typedef struct packed {
        logic [CLUS_W-1:0]   result_cluster;
        logic [STATUS_W-1:0] status;
        logic [FREED_W-1:0]  freed_count;
    } t_result;

    function automatic logic usable(input logic [CLUS_W-1:0] c,
                                    input logic [SIZE_W-1:0] size);
        return (c >= CLUS_FIRST) && (32'(c) < 32'(size)) && (c <= CLUS_LAST);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/fct_ram.sv =====
// ----------------------------------------------------------------------------
// fct_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fct_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/fct_ostage.sv =====
// ----------------------------------------------------------------------------
// fct_ostage
// Two-entry output stage: result register plus skid slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fct_ostage (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire fct_pkg::t_result i_push_data,
    output logic                  o_push_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output fct_pkg::t_result      o_out_data
);
    import fct_pkg::*;

    logic    r_out_v, n_out_v;
    logic    r_hold_v, n_hold_v;
    t_result r_out, r_hold;
    logic    out_free;

    assign out_free     = !r_out_v || i_out_ready;
    assign o_push_ready = !r_hold_v;
    assign o_out_valid  = r_out_v;
    assign o_out_data   = r_out;

    always_comb begin
        n_out_v  = r_out_v;
        n_hold_v = r_hold_v;
        if (out_free) begin
            n_out_v  = r_hold_v || i_push;
            n_hold_v = 1'b0;
        end else if (i_push) begin
            n_hold_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_hold_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_hold_v <= n_hold_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_hold_v) begin
                r_out <= r_hold;
            end else if (i_push) begin
                r_out <= i_push_data;
            end
        end else if (i_push) begin
            r_hold <= i_push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fct_ctrl.sv =====
// ----------------------------------------------------------------------------
// fct_ctrl
// Command sequencer: table clear, read-modify-write, free scan, chain walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fct_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [fct_pkg::SIZE_W-1:0]    i_size,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [fct_pkg::CMD_W-1:0]     i_cmd,
    input  wire logic [fct_pkg::CLUS_W-1:0]    i_cluster,
    input  wire logic [fct_pkg::CLUS_W-1:0]    i_link_value,
    input  wire logic                          i_push_ready,
    output logic                               o_push,
    output fct_pkg::t_result                   o_push_data,
    output logic                               o_we,
    output logic [fct_pkg::ADDR_W-1:0]         o_waddr,
    output logic [fct_pkg::CLUS_W-1:0]         o_wdata,
    output logic [fct_pkg::ADDR_W-1:0]         o_raddr,
    input  wire logic [fct_pkg::CLUS_W-1:0]    i_rdata
);
    import fct_pkg::*;

    t_state              r_state, n_state;
    logic [CMD_W-1:0]    r_cmd, n_cmd;
    logic [CLUS_W-1:0]   r_clus, n_clus;
    logic [CLUS_W-1:0]   r_link, n_link;
    logic [SIZE_W-1:0]   r_ptr, n_ptr;
    logic [ADDR_W-1:0]   r_chk, n_chk;
    logic                r_pend, n_pend;
    logic [FREED_W-1:0]  r_freed, n_freed;
    logic                r_byp;
    logic [CLUS_W-1:0]   r_byp_data;
    logic [CLUS_W-1:0]   rd;
    logic [FREED_W-1:0]  freed_inc;
    logic                accept;

    assign rd        = r_byp ? r_byp_data : i_rdata;
    assign freed_inc = r_freed + FREED_W'(1);
    assign accept    = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_clus      = r_clus;
        n_link      = r_link;
        n_ptr       = r_ptr;
        n_chk       = r_chk;
        n_pend      = r_pend;
        n_freed     = r_freed;
        o_in_ready  = 1'b0;
        o_we        = 1'b0;
        o_waddr     = r_clus[ADDR_W-1:0];
        o_wdata     = '0;
        o_raddr     = r_ptr[ADDR_W-1:0];
        o_push      = 1'b0;
        o_push_data = '0;

        unique case (r_state)
            S_CLEAR: begin
                o_we    = 1'b1;
                o_waddr = r_ptr[ADDR_W-1:0];
                n_ptr   = r_ptr + SIZE_W'(1);
                if (r_ptr == SIZE_W'(TABLE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                o_in_ready = i_push_ready;
                o_raddr    = i_cluster[ADDR_W-1:0];
                if (accept) begin
                    n_cmd   = i_cmd;
                    n_clus  = i_cluster;
                    n_link  = i_link_value;
                    n_freed = '0;
                    n_pend  = 1'b0;
                    n_ptr   = SIZE_W'(CLUS_FIRST);
                    n_state = (i_cmd == CMD_ALLOC) ? S_ALLOC : S_EXEC;
                end
            end

            S_EXEC: begin
                o_push  = 1'b1;
                n_state = S_IDLE;
                case (r_cmd) inside
                    CMD_NEXT: begin
                        if (!usable(r_clus, i_size)) begin
                            o_push_data.status = STAT_INVALID;
                        end else if (rd >= EOC_FIRST) begin
                            o_push_data.result_cluster = EOC_MARK;
                        end else if (usable(rd, i_size)) begin
                            o_push_data.result_cluster = rd;
                        end else begin
                            o_push_data.status = STAT_BROKEN;
                        end
                    end
                    CMD_FREE, CMD_MARK_LAST: begin
                        if (!usable(r_clus, i_size)) begin
                            o_push_data.status = STAT_INVALID;
                        end else begin
                            o_we    = 1'b1;
                            o_wdata = (r_cmd == CMD_FREE) ? '0 : EOC_MARK;
                        end
                    end
                    CMD_CHAIN: begin
                        if (!usable(r_clus, i_size) || !usable(r_link, i_size)) begin
                            o_push_data.status = STAT_INVALID;
                        end else begin
                            o_we    = 1'b1;
                            o_wdata = r_link;
                        end
                    end
                    CMD_RAW_LOAD: begin
                        if (32'(r_clus) >= 32'(i_size)) begin
                            o_push_data.status = STAT_INVALID;
                        end else begin
                            o_we    = 1'b1;
                            o_wdata = r_link;
                        end
                    end
                    CMD_FREE_CHAIN: begin
                        if (!usable(r_clus, i_size)) begin
                            o_push_data.status = STAT_INVALID;
                        end else begin
                            o_we = 1'b1;
                            if (rd >= EOC_FIRST) begin
                                o_push_data.freed_count = freed_inc;
                            end else if (!usable(rd, i_size)) begin
                                o_push_data.status      = STAT_BROKEN;
                                o_push_data.freed_count = freed_inc;
                            end else begin
                                o_push  = 1'b0;
                                n_state = S_EXEC;
                                n_clus  = rd;
                                n_freed = freed_inc;
                                o_raddr = rd[ADDR_W-1:0];
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end

            S_ALLOC: begin
                if (r_pend && (rd == '0)) begin
                    o_we                       = 1'b1;
                    o_waddr                    = r_chk;
                    o_wdata                    = EOC_MARK;
                    o_push                     = 1'b1;
                    o_push_data.result_cluster = CLUS_W'(r_chk);
                    n_state                    = S_IDLE;
                end else if (r_ptr >= i_size) begin
                    o_push             = 1'b1;
                    o_push_data.status = STAT_FULL;
                    n_state            = S_IDLE;
                end else begin
                    o_raddr = r_ptr[ADDR_W-1:0];
                    n_chk   = r_ptr[ADDR_W-1:0];
                    n_pend  = 1'b1;
                    n_ptr   = r_ptr + SIZE_W'(1);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ptr   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_clus     <= n_clus;
        r_link     <= n_link;
        r_chk      <= n_chk;
        r_freed    <= n_freed;
        r_byp      <= o_we && (o_waddr == o_raddr);
        r_byp_data <= o_wdata;
    end

endmodule

`default_nettype wire

// ===== rtl/fat16_cluster_table_engine_unit.sv =====
// ----------------------------------------------------------------------------
// fat16_cluster_table_engine_unit
// FAT16 allocation table engine: lookup, allocate, free, chain and walk.
// ----------------------------------------------------------------------------
// After reset the block clears every entry of the table memory and accepts
// no command meanwhile; configuration writes are taken at any time. Next,
// free, chain, mark last, raw load and an unused code read the entry of the
// single table RAM and write it back where the command changes it. Allocate
// scans from cluster 2 at one entry per cycle up to the configured table
// size, marks the first free entry as end of chain, or reports the table
// full. Free chain follows one link per cycle and reports the clusters
// freed. A result waits in a two-entry output stage, so a stalled consumer
// does not block the next command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fat16_cluster_table_engine_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [fct_pkg::CFG_W-1:0]      i_cfg_table_entries,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [fct_pkg::CMD_W-1:0]      i_cmd,
    input  wire logic [fct_pkg::CLUS_W-1:0]     i_cluster,
    input  wire logic [fct_pkg::CLUS_W-1:0]     i_link_value,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [fct_pkg::CLUS_W-1:0]          o_result_cluster,
    output logic [fct_pkg::STATUS_W-1:0]        o_status,
    output logic [fct_pkg::FREED_W-1:0]         o_freed_count
);
    import fct_pkg::*;

    logic [SIZE_W-1:0] r_size, n_size;
    logic              push, push_ready;
    t_result           push_data, out_data;
    logic              we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [CLUS_W-1:0] wdata, rdata;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (32'(i_cfg_table_entries) > TABLE_DEPTH) begin
            n_size = SIZE_W'(TABLE_DEPTH);
        end else if (32'(i_cfg_table_entries) < SIZE_MIN) begin
            n_size = SIZE_W'(SIZE_MIN);
        end else begin
            n_size = SIZE_W'(i_cfg_table_entries);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_W'(TABLE_DEPTH);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_size <= n_size;
        end
    end

    fct_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_size       (r_size),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_cluster    (i_cluster),
        .i_link_value (i_link_value),
        .i_push_ready (push_ready),
        .o_push       (push),
        .o_push_data  (push_data),
        .o_we         (we),
        .o_waddr      (waddr),
        .o_wdata      (wdata),
        .o_raddr      (raddr),
        .i_rdata      (rdata)
    );

    fct_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (CLUS_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    fct_ostage u_ostage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_data  (push_data),
        .o_push_ready (push_ready),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (out_data)
    );

    assign o_result_cluster = out_data.result_cluster;
    assign o_status         = out_data.status;
    assign o_freed_count    = out_data.freed_count;

endmodule

`default_nettype wire
